// ----- hw/rtl/iabst_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// iabst_pkg
// Shared types and constants of the implicit-index binary search tree.
// ----------------------------------------------------------------------------
package iabst_pkg;

   localparam int TABLE_SLOTS_DEF = 127;
   localparam int KEY_W           = 32;
   localparam int SLOT_W          = 7;
   localparam int STATUS_W        = 2;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_SEARCH = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 2'd0,
      ST_FULL      = 2'd1,
      ST_FOUND     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic wr_valid;
   } mem_cmd_type;

endpackage
`default_nettype wire

// ----- hw/rtl/iabst_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// iabst_if
// Request and response channels of the search tree: valid/ready plus payload.
// ----------------------------------------------------------------------------
interface iabst_req_if;
   logic                               valid;
   logic                               ready;
   logic                               mode;
   logic signed [iabst_pkg::KEY_W-1:0] key;
   logic [iabst_pkg::SLOT_W-1:0]       start_slot;

   modport source (output valid, mode, key, start_slot, input ready);
   modport sink (input valid, mode, key, start_slot, output ready);
endinterface

interface iabst_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [iabst_pkg::STATUS_W-1:0]  status;
   logic [iabst_pkg::SLOT_W-1:0]    slot_index;

   modport source (output valid, status, slot_index, input ready);
   modport sink (input valid, status, slot_index, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/iabst_slot_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// iabst_slot_mem
// Slot table: key and valid flag per slot, one write and one registered read.
// ----------------------------------------------------------------------------
module iabst_slot_mem #(
   parameter int TABLE_SLOTS = iabst_pkg::TABLE_SLOTS_DEF,
   parameter int NW          = $clog2(TABLE_SLOTS + 1)
) (
   input  wire                          clock,
   input  iabst_pkg::mem_cmd_type       cmd,
   input  wire [NW-1:0]                 rd_addr,
   input  wire [NW-1:0]                 wr_addr,
   input  wire [iabst_pkg::KEY_W-1:0]   wr_key,
   output logic                         rd_valid,
   output logic [iabst_pkg::KEY_W-1:0]  rd_key
);
   import iabst_pkg::*;

   logic [KEY_W:0] slot_mem [1:TABLE_SLOTS];
   logic [KEY_W:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         slot_mem[wr_addr] <= {cmd.wr_valid, wr_key};
      end
      if (cmd.rd_en) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
   end

   assign rd_valid = rd_data_ff[KEY_W];
   assign rd_key   = rd_data_ff[KEY_W-1:0];

endmodule
`default_nettype wire

// ----- hw/rtl/iabst_walk.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// iabst_walk
// Tree walk sequencer: clearing pass, one slot per cycle, result register.
// ----------------------------------------------------------------------------
module iabst_walk #(
   parameter int TABLE_SLOTS = iabst_pkg::TABLE_SLOTS_DEF,
   parameter int NW          = $clog2(TABLE_SLOTS + 1)
) (
   input  wire                          clock,
   input  wire                          reset,
   iabst_req_if.sink                    req_chan,
   iabst_rsp_if.source                  rsp_chan,
   output iabst_pkg::mem_cmd_type       mem_cmd,
   output logic [NW-1:0]                rd_addr,
   output logic [NW-1:0]                wr_addr,
   output logic [iabst_pkg::KEY_W-1:0]  wr_key,
   input  wire                          rd_valid,
   input  wire [iabst_pkg::KEY_W-1:0]   rd_key
);
   import iabst_pkg::*;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EVAL,
      S_DONE
   } state_type;

   localparam logic [NW:0]   CHILD_MAX = (NW+1)'(TABLE_SLOTS);
   localparam logic [NW-1:0] LAST_SLOT = NW'(TABLE_SLOTS);
   localparam logic [NW-1:0] ROOT_SLOT = NW'(1);

   state_type          state_ff, state_in;
   logic [NW-1:0]      node_ff, node_in;
   logic [NW-1:0]      clr_ff, clr_in;
   logic               mode_ff, mode_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   status_type         res_status_ff, res_status_in;
   logic [SLOT_W-1:0]  res_slot_ff, res_slot_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;

   logic               go_right;
   logic [NW:0]        child;
   logic               child_over;
   logic               start_ok;

   assign go_right   = !($signed(key_ff) < $signed(rd_key));
   assign child      = {node_ff, go_right};
   assign child_over = child > CHILD_MAX;
   assign start_ok   = (req_chan.start_slot != '0) &&
                       (32'(req_chan.start_slot) <= TABLE_SLOTS);

   assign req_chan.ready      = (state_ff == S_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.slot_index = rsp_slot_ff;

   always_comb begin
      state_in      = state_ff;
      node_in       = node_ff;
      clr_in        = clr_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      mem_cmd       = '0;
      rd_addr       = node_ff;
      wr_addr       = node_ff;
      wr_key        = key_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            mem_cmd.wr_en = 1'b1;
            wr_addr       = clr_ff;
            if (clr_ff == LAST_SLOT) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + NW'(1);
            end
         end
         S_IDLE: begin
            if (req_chan.valid) begin
               mode_in = req_chan.mode;
               key_in  = req_chan.key;
               if (req_chan.mode == MODE_INSERT) begin
                  node_in       = ROOT_SLOT;
                  rd_addr       = ROOT_SLOT;
                  mem_cmd.rd_en = 1'b1;
                  state_in      = S_EVAL;
               end else if (start_ok) begin
                  node_in       = NW'(req_chan.start_slot);
                  rd_addr       = NW'(req_chan.start_slot);
                  mem_cmd.rd_en = 1'b1;
                  state_in      = S_EVAL;
               end else begin
                  res_status_in = ST_NOT_FOUND;
                  res_slot_in   = '0;
                  state_in      = S_DONE;
               end
            end
         end
         S_EVAL: begin
            if (!rd_valid) begin
               res_slot_in = SLOT_W'(node_ff);
               state_in    = S_DONE;
               if (mode_ff == MODE_INSERT) begin
                  mem_cmd.wr_en    = 1'b1;
                  mem_cmd.wr_valid = 1'b1;
                  res_status_in    = ST_INSERTED;
               end else begin
                  res_status_in = ST_NOT_FOUND;
               end
            end else if ((mode_ff == MODE_SEARCH) && (key_ff == rd_key)) begin
               res_status_in = ST_FOUND;
               res_slot_in   = SLOT_W'(node_ff);
               state_in      = S_DONE;
            end else if (child_over) begin
               res_status_in = (mode_ff == MODE_INSERT) ? ST_FULL : ST_NOT_FOUND;
               res_slot_in   = '0;
               state_in      = S_DONE;
            end else begin
               node_in       = child[NW-1:0];
               rd_addr       = child[NW-1:0];
               mem_cmd.rd_en = 1'b1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= ROOT_SLOT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      node_ff       <= node_in;
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   a_no_rw_overlap : assert property (@(posedge clock) disable iff (reset)
      !(mem_cmd.rd_en && mem_cmd.wr_en))
      else $error("slot table read and write in the same cycle");

   a_eval_has_read : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL) |-> $past(mem_cmd.rd_en))
      else $error("walk step without a preceding slot read");

   a_eval_node_nonzero : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL) |-> (node_ff != '0))
      else $error("walk on slot zero");

   a_clear_blocks_req : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_chan.ready)
      else $error("request taken during clearing pass");

   a_done_loads_rsp : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready)) |=> rsp_valid_ff)
      else $error("result not presented after walk");

endmodule
`default_nettype wire

// ----- hw/rtl/implicit_array_bst_insert_search.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// implicit_array_bst_insert_search
// Binary search tree in a slot table, slot 1 the root, children 2n and 2n+1.
//
// req_chan carries one transaction per operation: mode (insert or search),
// a signed 32-bit key and, for a search, the start slot. rsp_chan returns
// one transaction per request: status and slot index.
// After reset a clearing pass marks every slot empty, one slot per cycle;
// req_chan.ready stays low until it completes.
// An operation walks the slots in turn from its start slot (the root for an
// insert), then loads its result into the output register; only then is
// the next request taken. A search whose start slot lies outside the table
// visits no slot. The walk reads one slot of the slot memory per cycle and
// compares it.
// The result sits in an output register; a stalled receiver holds it there
// while the next request is walked, and the walk waits for the register to
// empty before presenting its own result.
// ----------------------------------------------------------------------------
module implicit_array_bst_insert_search #(
   parameter int TABLE_SLOTS = iabst_pkg::TABLE_SLOTS_DEF
) (
   input  wire          clock,
   input  wire          reset,
   iabst_req_if.sink    req_chan,
   iabst_rsp_if.source  rsp_chan
);
   import iabst_pkg::*;

   localparam int NW = $clog2(TABLE_SLOTS + 1);

   mem_cmd_type       mem_cmd;
   logic [NW-1:0]     rd_addr;
   logic [NW-1:0]     wr_addr;
   logic [KEY_W-1:0]  wr_key;
   logic              rd_valid;
   logic [KEY_W-1:0]  rd_key;

   iabst_walk #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .NW          (NW)
   ) u_walk (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .mem_cmd  (mem_cmd),
      .rd_addr  (rd_addr),
      .wr_addr  (wr_addr),
      .wr_key   (wr_key),
      .rd_valid (rd_valid),
      .rd_key   (rd_key)
   );

   iabst_slot_mem #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .NW          (NW)
   ) u_slot_mem (
      .clock    (clock),
      .cmd      (mem_cmd),
      .rd_addr  (rd_addr),
      .wr_addr  (wr_addr),
      .wr_key   (wr_key),
      .rd_valid (rd_valid),
      .rd_key   (rd_key)
   );

endmodule
`default_nettype wire
